// ===== rtl/rbnh_pkg.sv =====
package rbnh_pkg;

    localparam int AXES = 3;

    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [2:0] REG_DIRECTION_X = 3'd3;
    localparam logic [2:0] REG_DIRECTION_Y = 3'd4;
    localparam logic [2:0] REG_DIRECTION_Z = 3'd5;
    localparam logic [2:0] REG_TOLERANCE   = 3'd6;

    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE   = 32'hFFFF_0000;
    localparam logic [31:0] NEAR_MAX  = 32'h7FFF_FFFF;

    typedef logic [AXES-1:0][31:0] vec3_t;

    typedef struct packed {
        vec3_t           lo;
        vec3_t           hi;
        vec3_t           mag;
        logic [AXES-1:0] outside;
        logic [AXES-1:0] neg;
        logic            restart;
    } box_item_t;

    typedef struct packed {
        logic        hit;
        logic        nearer;
        logic        in_box;
        logic [31:0] distance;
        logic [31:0] nearest;
    } box_result_t;

endpackage

// ===== rtl/rbnh_front.sv =====
module rbnh_front
    import rbnh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  vec3_t       origin,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [191:0] in_data,
    input  logic        in_restart,
    output logic        head_valid,
    output box_item_t   head,
    input  logic        pop
);

    box_item_t       item;
    box_item_t       fifo_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    logic [32:0]     diff_lo;
    logic [32:0]     diff_hi;

    always_comb
    begin
        item = '0;
        item.restart = in_restart;
        diff_lo = '0;
        diff_hi = '0;
        for (int a = 0; a < AXES; a++)
        begin
            item.lo[a] = in_data[32*a +: 32];
            item.hi[a] = in_data[32*(a+3) +: 32];
            diff_lo = {item.lo[a][31], item.lo[a]} - {origin[a][31], origin[a]};
            diff_hi = {origin[a][31], origin[a]} - {item.hi[a][31], item.hi[a]};
            if ($signed(origin[a]) < $signed(item.lo[a]))
            begin
                item.outside[a] = 1'b1;
                item.mag[a]     = diff_lo[31:0];
            end
            else if ($signed(origin[a]) > $signed(item.hi[a]))
            begin
                item.outside[a] = 1'b1;
                item.neg[a]     = 1'b1;
                item.mag[a]     = diff_hi[31:0];
            end
        end
    end

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== rtl/rbnh_div.sv =====
module rbnh_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num_mag,
    input  logic [31:0] den_mag,
    input  logic        neg,
    output logic        done,
    output logic [31:0] quotient
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} div_state_t;

    div_state_t  state_reg;
    logic [32:0] rem_reg;
    logic [47:0] quo_reg;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic [5:0]  count_reg;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    assign rem_sh  = {rem_reg[31:0], quo_reg[47]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign done    = (state_reg == S_DONE);

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > 48'h0000_8000_0000)
            begin
                quotient = 32'h8000_0000;
            end
            else
            begin
                quotient = 32'd0 - quo_reg[31:0];
            end
        end
        else if (quo_reg > 48'h0000_7FFF_FFFF)
        begin
            quotient = 32'h7FFF_FFFF;
        end
        else
        begin
            quotient = quo_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rem_reg   <= '0;
            quo_reg   <= '0;
            den_reg   <= '0;
            neg_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= {num_mag, 16'd0};
                        den_reg   <= den_mag;
                        neg_reg   <= neg;
                        count_reg <= 6'd47;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (!rem_sub[32])
                    begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[46:0], 1'b0};
                    end
                    count_reg <= count_reg - 6'd1;
                    if (count_reg == 6'd0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rbnh_back.sv =====
module rbnh_back
    import rbnh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  vec3_t       origin,
    input  vec3_t       direction,
    input  logic [15:0] tolerance,
    input  logic        head_valid,
    input  box_item_t   head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output box_result_t out_result
);

    typedef enum logic [2:0] {S_IDLE, S_AXIS, S_DIV, S_PICK, S_MUL, S_CHK, S_DONE} back_state_t;

    back_state_t  state_reg;
    box_item_t    item_reg;
    logic [1:0]   axis_reg;
    vec3_t        cand_reg;
    logic [1:0]   pick_reg;
    logic         hit_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]  nearest_reg;
    logic         out_valid_reg;
    box_result_t  result_reg;

    logic         div_start;
    logic         div_done;
    logic [31:0]  div_q;
    logic [31:0]  dir_a;
    logic [31:0]  den_mag;
    logic [1:0]   pick_next;
    logic         in_box;
    logic signed [49:0] point;
    logic signed [49:0] bound_lo;
    logic signed [49:0] bound_hi;
    logic [31:0]  near_base;
    logic [31:0]  hit_dist;
    logic         nearer;

    assign dir_a     = direction[axis_reg];
    assign den_mag   = dir_a[31] ? (32'd0 - dir_a) : dir_a;
    assign in_box    = ~|item_reg.outside;
    assign div_start = (state_reg == S_AXIS) && item_reg.outside[axis_reg] && (dir_a != 32'd0);
    assign pop       = (state_reg == S_IDLE) && head_valid;

    rbnh_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_mag  (item_reg.mag[axis_reg]),
        .den_mag  (den_mag),
        .neg      (item_reg.neg[axis_reg] ^ dir_a[31]),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        pick_next = 2'd0;
        if ($signed(cand_reg[1]) > $signed(cand_reg[0]))
        begin
            pick_next = 2'd1;
        end
        if ($signed(cand_reg[2]) > $signed(cand_reg[pick_next]))
        begin
            pick_next = 2'd2;
        end
    end

    always_comb
    begin
        point    = 50'($signed(origin[axis_reg])) + 50'(prod_reg >>> 16);
        bound_lo = 50'($signed(item_reg.lo[axis_reg])) - 50'($signed({1'b0, tolerance}));
        bound_hi = 50'($signed(item_reg.hi[axis_reg])) + 50'($signed({1'b0, tolerance}));
        near_base = item_reg.restart ? NEAR_MAX : nearest_reg;
        hit_dist  = (hit_reg && !in_box) ? cand_reg[pick_reg] : 32'd0;
        nearer    = hit_reg && ($signed(hit_dist) <= $signed(near_base));
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            axis_reg      <= 2'd0;
            cand_reg      <= '0;
            pick_reg      <= 2'd0;
            hit_reg       <= 1'b0;
            prod_reg      <= '0;
            nearest_reg   <= NEAR_MAX;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        item_reg  <= head;
                        axis_reg  <= 2'd0;
                        cand_reg  <= {NEG_ONE, NEG_ONE, NEG_ONE};
                        state_reg <= S_AXIS;
                    end
                end
                S_AXIS:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        cand_reg[axis_reg] <= div_q;
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= S_PICK;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_AXIS;
                        end
                    end
                end
                S_PICK:
                begin
                    pick_reg <= pick_next;
                    axis_reg <= 2'd0;
                    if (in_box)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (cand_reg[pick_next][31])
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (axis_reg == pick_reg)
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        prod_reg  <= $signed(cand_reg[pick_reg]) * $signed(dir_a);
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (point < bound_lo || point > bound_hi)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        nearest_reg         <= nearer ? hit_dist : near_base;
                        result_reg.hit      <= hit_reg;
                        result_reg.nearer   <= nearer;
                        result_reg.in_box   <= in_box;
                        result_reg.distance <= hit_dist;
                        result_reg.nearest  <= nearer ? hit_dist : near_base;
                        out_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_nearer_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.nearer |-> result_reg.hit)
        else $error("nearest update without a hit");

    a_in_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.in_box |-> result_reg.hit && result_reg.distance == 32'd0)
        else $error("inside box must hit at distance zero");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.hit |-> result_reg.distance == 32'd0)
        else $error("missed box must report distance zero");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == S_AXIS)
        else $error("popped beat not taken into work");

endmodule

// ===== rtl/ray_box_nearest_hit.sv =====
// A box that holds the origin, or whose chosen plane distance is negative, goes from the
// accepted beat to the result without checking the other axes; else they are checked in turn.
// Each axis whose origin is outside the slab with a nonzero direction also passes through one
// shared bit-serial divider, and output stalls hold the finished box back.
// One box is worked on at a time; a two-entry queue lets two more beats wait at the input.
// Reset: origin 0, direction (0, 0, 1.0), tolerance 1, nearest distance at maximum.
module ray_box_nearest_hit
    import rbnh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z
    input  logic [191:0] s_tdata,
    // restart_search
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_distance, nearest_distance
    output logic [63:0]  m_tdata,
    // box_intersected, became_nearest, origin_inside
    output logic [2:0]   m_tuser
);

    vec3_t       origin_reg;
    vec3_t       direction_reg;
    logic [15:0] tolerance_reg;
    logic        head_valid;
    box_item_t   head;
    logic        pop;
    box_result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg    <= '0;
            direction_reg <= {Q_ONE, 32'd0, 32'd0};
            tolerance_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:    origin_reg[0]    <= cfg_data;
                REG_ORIGIN_Y:    origin_reg[1]    <= cfg_data;
                REG_ORIGIN_Z:    origin_reg[2]    <= cfg_data;
                REG_DIRECTION_X: direction_reg[0] <= cfg_data;
                REG_DIRECTION_Y: direction_reg[1] <= cfg_data;
                REG_DIRECTION_Z: direction_reg[2] <= cfg_data;
                REG_TOLERANCE:   tolerance_reg    <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    rbnh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .origin     (origin_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_restart (s_tuser),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    rbnh_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .origin     (origin_reg),
        .direction  (direction_reg),
        .tolerance  (tolerance_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {result.nearest, result.distance};
    assign m_tuser = {result.in_box, result.nearer, result.hit};

endmodule

// ===== bench/ray_box_nearest_hit_tb.sv =====
`timescale 1ns / 1ps

module ray_box_nearest_hit_tb;
    import rbnh_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 200;
    localparam longint ONE = 65536;
    localparam longint NEAREST_MAX = 64'sd2147483647;

    typedef struct {
        longint lo[3];
        longint hi[3];
        bit     restart;
    } box_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = REG_ORIGIN_X;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;

    longint model_origin[3];
    longint ray_dir[3];
    longint edge_tol;
    longint nearest_dist;

    box_result_t pending_hits[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    ray_box_nearest_hit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ray_box_nearest_hit regression: fail");
            $finish;
        end
    end

    function automatic longint clamp32(longint x);
        if (x > NEAREST_MAX)
            return NEAREST_MAX;
        if (x < -NEAREST_MAX - 1)
            return -NEAREST_MAX - 1;
        return x;
    endfunction

    function automatic longint as_signed32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // Candidate-plane test; updates the tracked nearest distance.
    function automatic box_result_t predict_hit(box_t b);
        box_result_t r;
        longint cand[3];
        longint plane;
        longint reach;
        longint hit_dist;
        bit in_box;
        bit hit;
        bit nearer;
        int pick;
        in_box = 1'b1;
        hit = 1'b0;
        nearer = 1'b0;
        hit_dist = 0;
        for (int a = 0; a < 3; a++)
            cand[a] = -ONE;
        if (b.restart)
            nearest_dist = NEAREST_MAX;
        for (int a = 0; a < 3; a++)
        begin
            if (model_origin[a] < b.lo[a])
                plane = b.lo[a];
            else if (model_origin[a] > b.hi[a])
                plane = b.hi[a];
            else
                continue;
            in_box = 1'b0;
            if (ray_dir[a] != 0)
                cand[a] = clamp32(((plane - model_origin[a]) * ONE) / ray_dir[a]);
        end
        if (in_box)
            hit = 1'b1;
        else
        begin
            pick = 0;
            if (cand[1] > cand[pick])
                pick = 1;
            if (cand[2] > cand[pick])
                pick = 2;
            if (cand[pick] >= 0)
            begin
                hit = 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    if (a != pick)
                    begin
                        reach = model_origin[a] + ((cand[pick] * ray_dir[a]) >>> 16);
                        if (reach < b.lo[a] - edge_tol || reach > b.hi[a] + edge_tol)
                            hit = 1'b0;
                    end
                end
                if (hit)
                    hit_dist = cand[pick];
            end
        end
        if (hit && hit_dist <= nearest_dist)
        begin
            nearest_dist = hit_dist;
            nearer = 1'b1;
        end
        r.hit = hit;
        r.nearer = nearer;
        r.in_box = in_box;
        r.distance = 32'(hit_dist);
        r.nearest = 32'(nearest_dist);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        fail_count++;
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        box_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_hits.size() == 0)
                report("unexpected beat", m_tdata[31:0], '0);
            else
            begin
                want = pending_hits.pop_front();
                if (m_tuser[0] !== want.hit)
                    report("box_intersected", m_tuser[0], want.hit);
                if (m_tuser[1] !== want.nearer)
                    report("became_nearest", m_tuser[1], want.nearer);
                if (m_tuser[2] !== want.in_box)
                    report("origin_inside", m_tuser[2], want.in_box);
                if (m_tdata[31:0] !== want.distance)
                    report("hit_distance", m_tdata[31:0], want.distance);
                if (m_tdata[63:32] !== want.nearest)
                    report("nearest_distance", m_tdata[63:32], want.nearest);
            end
        end
    end

    // Called at a falling edge; leaves the write enable low at a falling edge.
    task automatic set_ray(longint o[3], longint d[3], longint tol);
        logic [2:0] idx[7];
        longint val[7];
        idx = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
                REG_DIRECTION_X, REG_DIRECTION_Y, REG_DIRECTION_Z, REG_TOLERANCE};
        val = '{o[0], o[1], o[2], d[0], d[1], d[2], tol};
        for (int k = 0; k < 7; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= 32'(val[k]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
        model_origin = o;
        ray_dir = d;
        edge_tol = tol & 64'hFFFF;
    endtask

    task automatic send_box(box_t b);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tdata <= {32'(b.hi[2]), 32'(b.hi[1]), 32'(b.hi[0]),
                    32'(b.lo[2]), 32'(b.lo[1]), 32'(b.lo[0])};
        s_tuser <= b.restart;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_hits.push_back(predict_hit(b));
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic box_t make_box(longint lx, longint ly, longint lz,
                                      longint hx, longint hy, longint hz, bit rs);
        box_t b;
        b.lo = '{lx, ly, lz};
        b.hi = '{hx, hy, hz};
        b.restart = rs;
        return b;
    endfunction

    function automatic box_t random_wide_box();
        box_t b;
        for (int a = 0; a < 3; a++)
        begin
            b.lo[a] = as_signed32($urandom);
            b.hi[a] = as_signed32($urandom);
        end
        b.restart = ($urandom_range(7) == 0);
        return b;
    endfunction

    // A box placed around a point on the ray, sometimes with a face near the tolerance edge.
    function automatic box_t aimed_box();
        box_t b;
        longint t;
        longint p;
        longint swap;
        int edge_axis;
        t = $urandom_range(0, 40 * 65536);
        edge_axis = ($urandom_range(9) == 0) ? $urandom_range(2) : -1;
        for (int a = 0; a < 3; a++)
        begin
            p = model_origin[a] + ((t * ray_dir[a]) >>> 16);
            b.lo[a] = clamp32(p - $urandom_range(0, 4 * 65536));
            b.hi[a] = clamp32(p + $urandom_range(0, 4 * 65536));
            if (a == edge_axis)
            begin
                if ($urandom_range(1))
                    b.hi[a] = clamp32(p - edge_tol - 1 + $urandom_range(0, 2));
                else
                    b.lo[a] = clamp32(p + edge_tol - 1 + $urandom_range(0, 2));
            end
            if ($urandom_range(19) == 0)
            begin
                swap = b.lo[a];
                b.lo[a] = b.hi[a];
                b.hi[a] = swap;
            end
        end
        b.restart = ($urandom_range(7) == 0);
        return b;
    endfunction

    function automatic box_t origin_box();
        box_t b;
        for (int a = 0; a < 3; a++)
        begin
            b.lo[a] = clamp32(model_origin[a] - $urandom_range(0, 3 * 65536));
            b.hi[a] = clamp32(model_origin[a] + $urandom_range(0, 3 * 65536));
        end
        b.restart = ($urandom_range(7) == 0);
        return b;
    endfunction

    function automatic longint small_dir();
        if ($urandom_range(4) == 0)
            return 0;
        return longint'($urandom_range(0, 4 * 65536)) - 2 * ONE;
    endfunction

    task automatic test_directed();
        longint o[3];
        longint d[3];
        o = '{0, 0, 0};
        d = '{0, 0, ONE};
        set_ray(o, d, 1);
        send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 1));
        send_box(make_box(-ONE, -ONE, 5 * ONE, ONE, ONE, 6 * ONE, 0));
        send_box(make_box(-ONE, -ONE, 5 * ONE, ONE, ONE, 6 * ONE, 1));
        send_box(make_box(-ONE, -ONE, 5 * ONE, ONE, ONE, 6 * ONE, 0));
        send_box(make_box(-ONE, -ONE, -6 * ONE, ONE, ONE, -5 * ONE, 0));
        send_box(make_box(2 * ONE, -ONE, -ONE, 3 * ONE, ONE, 9 * ONE, 0));
        send_box(make_box(2, -ONE, 5 * ONE, 3 * ONE, ONE, 6 * ONE, 1));
        send_box(make_box(1, -ONE, 5 * ONE, 3 * ONE, ONE, 6 * ONE, 0));
        send_box(make_box(-ONE, -ONE, 6 * ONE, ONE, ONE, 5 * ONE, 0));
        send_box(make_box(-NEAREST_MAX - 1, -NEAREST_MAX - 1, -NEAREST_MAX - 1,
                          NEAREST_MAX, NEAREST_MAX, NEAREST_MAX, 1));
        send_box(make_box(NEAREST_MAX, NEAREST_MAX, NEAREST_MAX,
                          -NEAREST_MAX - 1, -NEAREST_MAX - 1, -NEAREST_MAX - 1, 1));
        drain();
        d = '{1, 0, 0};
        set_ray(o, d, 0);
        send_box(make_box(64'sh7FFF0000, -ONE, -ONE, NEAREST_MAX, ONE, ONE, 1));
        send_box(make_box(3 * ONE, -ONE, -ONE, 4 * ONE, ONE, ONE, 0));
        drain();
        d = '{-ONE, 0, 0};
        set_ray(o, d, 65535);
        send_box(make_box(-10 * ONE, -ONE, -ONE, -9 * ONE, ONE, ONE, 1));
        send_box(make_box(9 * ONE, -ONE, -ONE, 10 * ONE, ONE, ONE, 0));
        send_box(make_box(-10 * ONE, 2 * ONE, -ONE, -9 * ONE, 3 * ONE, ONE, 0));
        drain();
    endtask

    task automatic test_aimed_rays(int idle_pct, int stall_pct);
        longint o[3];
        longint d[3];
        int sel;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int r = 0; r < 5; r++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                o[a] = longint'($urandom_range(0, 100 * 65536)) - 50 * ONE;
                d[a] = small_dir();
            end
            set_ray(o, d, ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 64));
            for (int k = 0; k < 50; k++)
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                    send_box(aimed_box());
                else if (sel < 85)
                    send_box(origin_box());
                else
                    send_box(random_wide_box());
            end
            drain();
        end
    endtask

    task automatic test_extreme_rays();
        longint o[3];
        longint d[3];
        longint picks[5];
        picks = '{-NEAREST_MAX - 1, NEAREST_MAX, 0, 1, -1};
        send_idle_pct = 20;
        recv_stall_pct = 20;
        for (int r = 0; r < 6; r++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                o[a] = (r < 3) ? picks[$urandom_range(4)] : as_signed32($urandom);
                d[a] = (r < 3) ? picks[$urandom_range(4)] : as_signed32($urandom);
            end
            set_ray(o, d, (r % 2 == 0) ? 65535 : 0);
            for (int k = 0; k < 40; k++)
                send_box(($urandom_range(1)) ? aimed_box() : random_wide_box());
            drain();
        end
    endtask

    initial
    begin
        model_origin = '{0, 0, 0};
        ray_dir = '{0, 0, ONE};
        edge_tol = 1;
        nearest_dist = NEAREST_MAX;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_aimed_rays(0, 0);
        test_aimed_rays(48, 0);
        test_aimed_rays(0, 48);
        test_aimed_rays(20, 20);
        test_extreme_rays();
        if (fail_count == 0)
            $display("ray_box_nearest_hit regression: pass");
        else
            $display("ray_box_nearest_hit regression: fail");
        $finish;
    end

endmodule

// ===== ray_box_nearest_hit.f =====
rtl/rbnh_pkg.sv
rtl/rbnh_front.sv
rtl/rbnh_div.sv
rtl/rbnh_back.sv
rtl/ray_box_nearest_hit.sv
bench/ray_box_nearest_hit_tb.sv
